>>> rtl/wsct_pkg.sv
package wsct_pkg;

    // Coordinate width of the wall ends and of the path points
    localparam int COORD_BITS = 20;
    localparam int EXT_BITS   = COORD_BITS - 1;

    // Differences of two coordinates
    localparam int DW  = COORD_BITS + 1;
    // Height bound relative to the path start: base + extent - start
    localparam int BW  = COORD_BITS + 2;
    // One cross-product term, and the difference of two of them
    localparam int PW  = 2 * DW;
    localparam int NW  = PW + 1;
    // Split of a numerator or denominator for the height products
    localparam int LO_W = (NW + 1) / 2;
    localparam int HI_W = NW - LO_W;
    // Partial product widths and the recombined product width
    localparam int LPW = LO_W + 1 + BW;
    localparam int HPW = HI_W + BW;
    localparam int SW  = NW + BW;

    // Stream payload widths
    localparam int N_IN_FIELDS = 6;
    localparam int S_TDATA_W   = ((N_IN_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;

    // Pipeline depth from the accepting edge to the output register
    localparam int NSTAGE = 7;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WALL_AX = 3'd0,
        REG_WALL_AZ = 3'd1,
        REG_WALL_AY = 3'd2,
        REG_WALL_AH = 3'd3,
        REG_WALL_BX = 3'd4,
        REG_WALL_BZ = 3'd5,
        REG_WALL_BY = 3'd6,
        REG_WALL_BH = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [NSTAGE-1:0] en;
        logic [NSTAGE-1:0] vld;
    } t_pipe_ctl;

endpackage

>>> rtl/wsct_pipe_ctl.sv
module wsct_pipe_ctl
    import wsct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] en;
    logic              chain;

    // A stage loads when it is empty or when the stage after it moves on
    always_comb begin
        chain = i_out_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || chain;
            chain = en[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NSTAGE-1];
    assign o_ctl.en    = en;
    assign o_ctl.vld   = r_vld;

endmodule

>>> rtl/wall_segment_crossing_test.sv
// Wall segment crossing test.
//
// Tests one motion path per item against a vertical wall held in eight
// configuration registers (end A and end B: x, z, base height, extent).
// Input channel (i_s_*): one path per item, start x/y/z then end x/y/z,
// 20-bit signed each. Output channel (o_m_*): one hit flag per path, in
// the order the paths came in.
// Configuration channel (i_cfg_*): register index 0..7 in list order and
// write data; always ready. Write only while no path is in flight.
//
// Throughput: one item per cycle unless a stall at the output backs up to
// the input, set by a seven-stage pipeline (differences, cross products,
// numerators, sign fix, split height products, recombine, compare) with a
// valid bit per stage. Each stage advances when it is empty or the next
// one advances, so a stall at the output fills the bubbles behind it before
// o_s_tready drops; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and clears every
// wall register to zero.
module wall_segment_crossing_test
    import wsct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // start_x, start_y, start_z, end_x, end_y, end_z (20 bits each)
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // hit in bit 0, zeros above
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data
);

    t_pipe_ctl ctl;

    // ---------------------------------------------------------------
    // Wall registers
    // ---------------------------------------------------------------
    logic signed [COORD_BITS-1:0] r_wall_ax, r_wall_az, r_wall_ay;
    logic signed [COORD_BITS-1:0] r_wall_bx, r_wall_bz, r_wall_by;
    logic        [EXT_BITS-1:0]   r_wall_ah, r_wall_bh;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_ax <= '0;
            r_wall_az <= '0;
            r_wall_ay <= '0;
            r_wall_ah <= '0;
            r_wall_bx <= '0;
            r_wall_bz <= '0;
            r_wall_by <= '0;
            r_wall_bh <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_WALL_AX: r_wall_ax <= i_cfg_data;
                REG_WALL_AZ: r_wall_az <= i_cfg_data;
                REG_WALL_AY: r_wall_ay <= i_cfg_data;
                REG_WALL_AH: r_wall_ah <= i_cfg_data[EXT_BITS-1:0];
                REG_WALL_BX: r_wall_bx <= i_cfg_data;
                REG_WALL_BZ: r_wall_bz <= i_cfg_data;
                REG_WALL_BY: r_wall_by <= i_cfg_data;
                REG_WALL_BH: r_wall_bh <= i_cfg_data[EXT_BITS-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control
    // ---------------------------------------------------------------
    wsct_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_ctl       (ctl)
    );

    // Unpack the path, first field in the lowest bits
    logic signed [COORD_BITS-1:0] in_sx, in_sy, in_sz, in_ex, in_ey, in_ez;

    assign in_sx = i_s_tdata[0*COORD_BITS +: COORD_BITS];
    assign in_sy = i_s_tdata[1*COORD_BITS +: COORD_BITS];
    assign in_sz = i_s_tdata[2*COORD_BITS +: COORD_BITS];
    assign in_ex = i_s_tdata[3*COORD_BITS +: COORD_BITS];
    assign in_ey = i_s_tdata[4*COORD_BITS +: COORD_BITS];
    assign in_ez = i_s_tdata[5*COORD_BITS +: COORD_BITS];

    // ---------------------------------------------------------------
    // Stage 1: path direction, start-to-wall offset, wall direction,
    // height bounds relative to the path start
    // ---------------------------------------------------------------
    logic signed [DW-1:0] r_s1_px, r_s1_py, r_s1_pz;
    logic signed [DW-1:0] r_s1_tx, r_s1_tz, r_s1_wx, r_s1_wz;
    logic signed [BW-1:0] r_s1_la, r_s1_ha, r_s1_lb, r_s1_hb;

    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r_s1_px <= DW'(in_ex) - DW'(in_sx);
            r_s1_py <= DW'(in_ey) - DW'(in_sy);
            r_s1_pz <= DW'(in_ez) - DW'(in_sz);
            r_s1_tx <= DW'(r_wall_ax) - DW'(in_sx);
            r_s1_tz <= DW'(r_wall_az) - DW'(in_sz);
            r_s1_wx <= DW'(r_wall_bx) - DW'(r_wall_ax);
            r_s1_wz <= DW'(r_wall_bz) - DW'(r_wall_az);
            r_s1_la <= BW'(r_wall_ay) - BW'(in_sy);
            r_s1_lb <= BW'(r_wall_by) - BW'(in_sy);
            // End B takes its own base, as end A does
            r_s1_ha <= BW'(r_wall_ay) + BW'($signed({1'b0, r_wall_ah})) - BW'(in_sy);
            r_s1_hb <= BW'(r_wall_by) + BW'($signed({1'b0, r_wall_bh})) - BW'(in_sy);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: the six cross-product terms
    // ---------------------------------------------------------------
    logic signed [PW-1:0] r_s2_m0, r_s2_m1, r_s2_m2, r_s2_m3, r_s2_m4, r_s2_m5;
    logic signed [DW-1:0] r_s2_py;
    logic signed [BW-1:0] r_s2_la, r_s2_ha, r_s2_lb, r_s2_hb;

    always_ff @(posedge i_clk) begin
        if (ctl.en[1]) begin
            r_s2_m0 <= PW'(r_s1_wx * r_s1_pz);
            r_s2_m1 <= PW'(r_s1_wz * r_s1_px);
            r_s2_m2 <= PW'(r_s1_tz * r_s1_px);
            r_s2_m3 <= PW'(r_s1_tx * r_s1_pz);
            r_s2_m4 <= PW'(r_s1_tz * r_s1_wx);
            r_s2_m5 <= PW'(r_s1_tx * r_s1_wz);
            r_s2_py <= r_s1_py;
            r_s2_la <= r_s1_la;
            r_s2_ha <= r_s1_ha;
            r_s2_lb <= r_s1_lb;
            r_s2_hb <= r_s1_hb;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: denominator and the two crossing numerators
    // ---------------------------------------------------------------
    logic signed [NW-1:0] r_s3_den, r_s3_rn, r_s3_sn;
    logic signed [DW-1:0] r_s3_py;
    logic signed [BW-1:0] r_s3_la, r_s3_ha, r_s3_lb, r_s3_hb;

    always_ff @(posedge i_clk) begin
        if (ctl.en[2]) begin
            r_s3_den <= NW'(r_s2_m0) - NW'(r_s2_m1);
            r_s3_rn  <= NW'(r_s2_m2) - NW'(r_s2_m3);
            r_s3_sn  <= NW'(r_s2_m4) - NW'(r_s2_m5);
            r_s3_py  <= r_s2_py;
            r_s3_la  <= r_s2_la;
            r_s3_ha  <= r_s2_ha;
            r_s3_lb  <= r_s2_lb;
            r_s3_hb  <= r_s2_hb;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: make the denominator non-negative, flag a parallel path
    // ---------------------------------------------------------------
    logic signed [NW-1:0] r_s4_den, r_s4_rn, r_s4_sn;
    logic                 r_s4_nz;
    logic signed [DW-1:0] r_s4_py;
    logic signed [BW-1:0] r_s4_la, r_s4_ha, r_s4_lb, r_s4_hb;
    logic                 s3_neg;

    assign s3_neg = r_s3_den[NW-1];

    always_ff @(posedge i_clk) begin
        if (ctl.en[3]) begin
            r_s4_den <= s3_neg ? -r_s3_den : r_s3_den;
            r_s4_rn  <= s3_neg ? -r_s3_rn  : r_s3_rn;
            r_s4_sn  <= s3_neg ? -r_s3_sn  : r_s3_sn;
            r_s4_nz  <= |r_s3_den;
            r_s4_py  <= r_s3_py;
            r_s4_la  <= r_s3_la;
            r_s4_ha  <= r_s3_ha;
            r_s4_lb  <= r_s3_lb;
            r_s4_hb  <= r_s3_hb;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: range checks on r and s; height products split into a
    // low (unsigned) and a high (signed) partial product
    // ---------------------------------------------------------------
    logic signed [LO_W:0]   s4_rn_lo, s4_den_lo;
    logic signed [HI_W-1:0] s4_rn_hi, s4_den_hi;
    logic signed [BW-1:0]   s4_py_b;

    assign s4_rn_lo  = $signed({1'b0, r_s4_rn[LO_W-1:0]});
    assign s4_den_lo = $signed({1'b0, r_s4_den[LO_W-1:0]});
    assign s4_rn_hi  = r_s4_rn[NW-1:LO_W];
    assign s4_den_hi = r_s4_den[NW-1:LO_W];
    assign s4_py_b   = BW'(r_s4_py);

    logic                  r_s5_ok;
    logic signed [LPW-1:0] r_s5_yl, r_s5_lal, r_s5_hal, r_s5_lbl, r_s5_hbl;
    logic signed [HPW-1:0] r_s5_yh, r_s5_lah, r_s5_hah, r_s5_lbh, r_s5_hbh;

    always_ff @(posedge i_clk) begin
        if (ctl.en[4]) begin
            r_s5_ok  <= r_s4_nz
                     && !r_s4_rn[NW-1] && !(r_s4_den < r_s4_rn)
                     && !r_s4_sn[NW-1] && !(r_s4_den < r_s4_sn);
            r_s5_yl  <= LPW'(s4_rn_lo * s4_py_b);
            r_s5_yh  <= HPW'(s4_rn_hi * s4_py_b);
            r_s5_lal <= LPW'(s4_den_lo * r_s4_la);
            r_s5_lah <= HPW'(s4_den_hi * r_s4_la);
            r_s5_hal <= LPW'(s4_den_lo * r_s4_ha);
            r_s5_hah <= HPW'(s4_den_hi * r_s4_ha);
            r_s5_lbl <= LPW'(s4_den_lo * r_s4_lb);
            r_s5_lbh <= HPW'(s4_den_hi * r_s4_lb);
            r_s5_hbl <= LPW'(s4_den_lo * r_s4_hb);
            r_s5_hbh <= HPW'(s4_den_hi * r_s4_hb);
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: recombine the partial products
    // ---------------------------------------------------------------
    logic                 r_s6_ok;
    logic signed [SW-1:0] r_s6_yn, r_s6_la, r_s6_ha, r_s6_lb, r_s6_hb;

    always_ff @(posedge i_clk) begin
        if (ctl.en[5]) begin
            r_s6_ok <= r_s5_ok;
            r_s6_yn <= (SW'(r_s5_yh)  <<< LO_W) + SW'(r_s5_yl);
            r_s6_la <= (SW'(r_s5_lah) <<< LO_W) + SW'(r_s5_lal);
            r_s6_ha <= (SW'(r_s5_hah) <<< LO_W) + SW'(r_s5_hal);
            r_s6_lb <= (SW'(r_s5_lbh) <<< LO_W) + SW'(r_s5_lbl);
            r_s6_hb <= (SW'(r_s5_hbh) <<< LO_W) + SW'(r_s5_hbl);
        end
    end

    // ---------------------------------------------------------------
    // Stage 7: height span at both ends; output register
    // ---------------------------------------------------------------
    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (ctl.en[6]) begin
            r_hit <= r_s6_ok
                  && !(r_s6_yn < r_s6_la) && !(r_s6_ha < r_s6_yn)
                  && !(r_s6_yn < r_s6_lb) && !(r_s6_hb < r_s6_yn);
        end
    end

    assign o_m_tdata = {{(M_TDATA_W-1){1'b0}}, r_hit};

endmodule

>>> rtl/wsct_checker.sv
module wsct_checker
    import wsct_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    // The pipeline is empty right after reset
    a_empty_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_m_tvalid
    ) else $error("result offered straight after reset");

    // With the output free, every stage can move, so the input must be open
    a_ready_when_free: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tready || !o_m_tvalid) |-> o_s_tready
    ) else $error("input closed although the output side is free");

    // Hold a stalled result
    a_hold_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid
    ) else $error("result dropped while stalled");

    a_hold_data: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata)
    ) else $error("result changed while stalled");

endmodule

bind wall_segment_crossing_test wsct_checker u_wsct_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> sim/crossing_check_pkg.sv
package crossing_check_pkg;
    import wsct_pkg::*;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [EXT_BITS-1:0]   t_extent;
    // Wide enough for every product of the exact crossing test
    typedef logic signed [127:0]          t_wide;

    typedef struct {
        t_coord sx, sy, sz;
        t_coord ex, ey, ez;
    } t_path;

    typedef struct {
        t_coord  ax, az, ay;
        t_extent ah;
        t_coord  bx, bz, by;
        t_extent bh;
    } t_wall;

    class crossing_scoreboard;
        t_wall wall;
        bit    hits_due[$];
        int    n_bad;

        function new();
            wall  = '{default: 0};
            n_bad = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [COORD_BITS-1:0] d);
            case (idx)
                REG_WALL_AX: wall.ax = d;
                REG_WALL_AZ: wall.az = d;
                REG_WALL_AY: wall.ay = d;
                REG_WALL_AH: wall.ah = d[EXT_BITS-1:0];
                REG_WALL_BX: wall.bx = d;
                REG_WALL_BZ: wall.bz = d;
                REG_WALL_BY: wall.by = d;
                REG_WALL_BH: wall.bh = d[EXT_BITS-1:0];
            endcase
        endfunction

        // Exact crossing test: quotients compared by cross-multiplying
        function bit crosses(t_path p);
            t_wide sx, sy, sz, px, py, pz;
            t_wide ax, az, ay, ah, bx, bz, by, bh;
            t_wide wx, wz, tx, tz, den, rn, sn, yn;
            sx = p.sx;  sy = p.sy;  sz = p.sz;
            px = p.ex;  py = p.ey;  pz = p.ez;
            px = px - sx;
            py = py - sy;
            pz = pz - sz;
            ax = wall.ax;  az = wall.az;  ay = wall.ay;  ah = wall.ah;
            bx = wall.bx;  bz = wall.bz;  by = wall.by;  bh = wall.bh;
            wx = bx - ax;
            wz = bz - az;
            den = wx * pz - wz * px;
            // parallel, collinear or zero length
            if (den == 0)
                return 1'b0;
            tz = az - sz;
            tx = ax - sx;
            rn = tz * px - tx * pz;
            sn = tz * wx - tx * wz;
            if (den < 0) begin
                den = -den;
                rn  = -rn;
                sn  = -sn;
            end
            if (rn < 0 || rn > den || sn < 0 || sn > den)
                return 1'b0;
            yn = rn * py;
            if (yn < (ay - sy) * den || yn > (ay + ah - sy) * den)
                return 1'b0;
            if (yn < (by - sy) * den || yn > (by + bh - sy) * den)
                return 1'b0;
            return 1'b1;
        endfunction

        function void note_path(t_path p);
            hits_due.push_back(crosses(p));
        endfunction

        function void flag(string what, logic [M_TDATA_W-1:0] want,
                           logic [M_TDATA_W-1:0] got);
            n_bad++;
            if (n_bad <= 10)
                $display("mismatch: %s: expected %02h, got %02h", what, want, got);
        endfunction

        function void check_hit(logic [M_TDATA_W-1:0] got);
            logic [M_TDATA_W-1:0] want;
            if (hits_due.size() == 0) begin
                flag("result with no path outstanding", '0, got);
                return;
            end
            want = M_TDATA_W'(hits_due.pop_front());
            if (got !== want)
                flag("hit", want, got);
        endfunction

        function int pending();
            return hits_due.size();
        endfunction
    endclass

endpackage

>>> sim/tb_top.sv
module tb_top;
    import wsct_pkg::*;
    import crossing_check_pkg::*;

    localparam int     CYCLE_LIMIT = 500_000;
    localparam int     PHASE_ITEMS = 250;
    localparam int     N_PHASES    = 8;
    // Long receiver hold-off: starts once this many results have come
    localparam int     HOLD_AT     = 400;
    localparam int     HOLD_CYCLES = 200;
    localparam longint C_MIN = -(longint'(1) << (COORD_BITS - 1));
    localparam longint C_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint E_MAX = (longint'(1) << EXT_BITS) - 1;

    typedef enum int {
        WALL_RANDOM,
        WALL_AXIS,
        WALL_CORNERS,
        WALL_CROSSED,
        WALL_NOISE
    } t_wall_kind;

    // Wall shape for each random phase; the extremes sit in the middle
    localparam t_wall_kind PHASE_WALLS [N_PHASES] = '{
        WALL_RANDOM, WALL_CORNERS, WALL_RANDOM, WALL_CROSSED,
        WALL_NOISE, WALL_RANDOM, WALL_AXIS, WALL_RANDOM
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b1;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [COORD_BITS-1:0] i_cfg_data  = '0;

    crossing_scoreboard board = new();

    // Idle densities in percent; the main sequence sets them per phase
    int     tx_idle_pct  = 0;
    int     rx_idle_pct  = 0;
    int     results_seen = 0;
    int     stall_left   = 0;
    bit     held_off     = 1'b0;
    longint cycles       = 0;

    wall_segment_crossing_test DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Saturate a wide coordinate into the signed field range
    function automatic t_coord clamp(longint v);
        if (v < C_MIN)
            return t_coord'(C_MIN);
        if (v > C_MAX)
            return t_coord'(C_MAX);
        return t_coord'(v);
    endfunction

    function automatic longint pick(longint lo, longint hi);
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    function automatic t_path path_of(longint sx, longint sy, longint sz,
                                      longint ex, longint ey, longint ez);
        t_path p;
        p.sx = clamp(sx);  p.sy = clamp(sy);  p.sz = clamp(sz);
        p.ex = clamp(ex);  p.ey = clamp(ey);  p.ez = clamp(ez);
        return p;
    endfunction

    function automatic t_wall make_wall(t_wall_kind kind);
        t_wall w;
        case (kind)
            WALL_AXIS: begin
                // A spans heights 0..500, B spans 100..600: shared band 100..500
                w.ax = clamp(-1000);  w.az = clamp(0);  w.ay = clamp(0);
                w.ah = t_extent'(500);
                w.bx = clamp(1000);   w.bz = clamp(0);  w.by = clamp(100);
                w.bh = t_extent'(500);
            end
            WALL_CORNERS: begin
                w.ax = clamp(C_MIN);  w.az = clamp(C_MIN);
                w.ay = clamp(C_MIN);  w.ah = t_extent'(E_MAX);
                w.bx = clamp(C_MAX);  w.bz = clamp(C_MAX);
                w.by = clamp(C_MIN);  w.bh = t_extent'(E_MAX);
            end
            WALL_CROSSED: begin
                // top of the range, with a zero extent at B
                w.ax = clamp(C_MAX);  w.az = clamp(C_MIN);
                w.ay = clamp(C_MAX);  w.ah = t_extent'(E_MAX);
                w.bx = clamp(C_MIN);  w.bz = clamp(C_MAX);
                w.by = clamp(C_MAX);  w.bh = '0;
            end
            WALL_NOISE: begin
                w.ax = t_coord'($urandom);   w.az = t_coord'($urandom);
                w.ay = t_coord'($urandom);   w.ah = t_extent'($urandom);
                w.bx = t_coord'($urandom);   w.bz = t_coord'($urandom);
                w.by = t_coord'($urandom);   w.bh = t_extent'($urandom);
            end
            default: begin
                w.ax = clamp(pick(-200000, 200000));
                w.az = clamp(pick(-200000, 200000));
                w.bx = clamp(pick(-200000, 200000));
                w.bz = clamp(pick(-200000, 200000));
                w.ay = clamp(pick(-100000, 100000));
                // keep the two spans overlapping most of the time
                if ($urandom_range(3) == 0)
                    w.by = clamp(pick(-100000, 100000));
                else
                    w.by = clamp(longint'(w.ay) + pick(-50000, 50000));
                w.ah = ($urandom_range(5) == 0) ? '0 : t_extent'(pick(0, 200000));
                w.bh = ($urandom_range(5) == 0) ? '0 : t_extent'(pick(0, 200000));
            end
        endcase
        return w;
    endfunction

    // A path through a point on the wall, with its y mostly inside both spans
    function automatic t_path make_crossing(t_wall w);
        t_path  p;
        longint ax = w.ax, az = w.az, bx = w.bx, bz = w.bz;
        longint ay = w.ay, ah = w.ah, by = w.by, bh = w.bh;
        longint k, cx, cz, mag, dx, dz, u, v, lo, hi, ylo, yhi;
        case ($urandom_range(9))
            0:       k = 0;
            1:       k = 1024;
            default: k = pick(0, 1024);
        endcase
        cx  = ax + (bx - ax) * k / 1024;
        cz  = az + (bz - az) * k / 1024;
        mag = longint'(1) << $urandom_range(18);
        dx  = pick(-mag, mag);
        dz  = pick(-mag, mag);
        // a zero share puts an end of the path on the crossing point
        u = ($urandom_range(9) == 0) ? 0 : pick(1, 256);
        v = ($urandom_range(9) == 0) ? 0 : pick(1, 256);
        p.sx = clamp(cx - dx * u / 256);
        p.sz = clamp(cz - dz * u / 256);
        p.ex = clamp(cx + dx * v / 256);
        p.ez = clamp(cz + dz * v / 256);
        lo  = (ay > by) ? ay : by;
        hi  = (ay + ah < by + bh) ? ay + ah : by + bh;
        ylo = clamp((lo < hi) ? lo : hi);
        yhi = clamp((lo < hi) ? hi : lo);
        if (lo <= hi && $urandom_range(3) != 0) begin
            case ($urandom_range(7))
                0:       begin p.sy = clamp(ylo); p.ey = clamp(ylo); end
                1:       begin p.sy = clamp(yhi); p.ey = clamp(yhi); end
                default: begin p.sy = clamp(pick(ylo, yhi)); p.ey = clamp(pick(ylo, yhi)); end
            endcase
        end else begin
            // near the bounds, on either side of them
            p.sy = clamp(pick(ylo - 4096, yhi + 4096));
            p.ey = clamp(pick(ylo - 4096, yhi + 4096));
        end
        return p;
    endfunction

    function automatic t_path make_noise();
        t_path p;
        p.sx = t_coord'($urandom);  p.sy = t_coord'($urandom);  p.sz = t_coord'($urandom);
        p.ex = t_coord'($urandom);  p.ey = t_coord'($urandom);  p.ez = t_coord'($urandom);
        return p;
    endfunction

    function automatic t_path make_random(t_wall w);
        t_path  p;
        longint ax = w.ax, az = w.az, bx = w.bx, bz = w.bz;
        longint sx, sz, m;
        int     roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return make_crossing(w);
        if (roll >= 78)
            return make_noise();
        // parallel to the wall, collinear with it, or of zero length
        p  = make_noise();
        sx = pick(-100000, 100000);
        sz = pick(-100000, 100000);
        m  = pick(-2, 2);
        case ($urandom_range(2))
            0:       p = path_of(sx, p.sy, sz, sx, p.ey, sz);
            1:       p = path_of(sx, p.sy, sz, sx + (bx - ax) * m, p.ey, sz + (bz - az) * m);
            default: p = path_of(ax, p.sy, az, bx, p.ey, bz);
        endcase
        return p;
    endfunction

    // Offer one path, after a random idle burst; leave tvalid high afterwards
    task automatic offer(t_path p);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= S_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'({p.ez, p.ey, p.ex, p.sz, p.sy, p.sx});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_path(p);
    endtask

    // Drop tvalid and wait until every path in flight has returned its flag
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Write all eight registers in a shuffled order; extents carry a random
    // spare top bit, which the block must drop
    task automatic write_wall(t_wall w);
        logic [COORD_BITS-1:0] vals [2**CFG_IDX_W];
        t_reg_idx              order [2**CFG_IDX_W];
        vals[REG_WALL_AX] = w.ax;
        vals[REG_WALL_AZ] = w.az;
        vals[REG_WALL_AY] = w.ay;
        vals[REG_WALL_AH] = {1'($urandom), w.ah};
        vals[REG_WALL_BX] = w.bx;
        vals[REG_WALL_BZ] = w.bz;
        vals[REG_WALL_BY] = w.by;
        vals[REG_WALL_BH] = {1'($urandom), w.bh};
        order = '{REG_WALL_AX, REG_WALL_AZ, REG_WALL_AY, REG_WALL_AH,
                  REG_WALL_BX, REG_WALL_BZ, REG_WALL_BY, REG_WALL_BH};
        order.shuffle();
        foreach (order[i]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[i];
            i_cfg_data  <= vals[order[i]];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            board.set_reg(order[i], vals[order[i]]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: check each accepted flag, then decide the next tready.
    // Random stalls come in bursts; once, hold off for a long stretch so the
    // pipeline fills and the block has to push back on the path side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b1;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                board.check_hit(o_m_tdata);
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= (stall_left == 0);
            end else if (!held_off && results_seen >= HOLD_AT) begin
                held_off   = 1'b1;
                stall_left = HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 12);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_wall wall_now;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers still at reset: a zero-length wall, so every path misses
        tx_idle_pct = 20;
        rx_idle_pct = 10;
        repeat (10) offer(make_noise());
        settle();

        // Directed paths against a wall along the x axis
        wall_now = make_wall(WALL_AXIS);
        write_wall(wall_now);
        offer(path_of(0, 300, -100, 0, 300, 100));        // clean crossing
        offer(path_of(0, 300, 100, 0, 300, -100));        // reversed direction
        offer(path_of(0, 300, 0, 0, 300, 100));           // starts on the wall
        offer(path_of(0, 300, -100, 0, 300, 0));          // ends on the wall
        offer(path_of(-1000, 300, -50, -1000, 300, 50));  // through end A
        offer(path_of(1000, 300, -50, 1000, 300, 50));    // through end B
        offer(path_of(1001, 300, -50, 1001, 300, 50));    // just past end B
        offer(path_of(0, 300, -100, 0, 300, -1));         // stops short
        offer(path_of(0, 100, -100, 0, 100, 100));        // on the lower bound
        offer(path_of(0, 99, -100, 0, 99, 100));          // inside A's span only
        offer(path_of(0, 500, -100, 0, 500, 100));        // on the upper bound
        offer(path_of(0, 501, -100, 0, 501, 100));        // inside B's span only
        offer(path_of(0, 0, -100, 0, 600, 100));          // rising, y 300 at wall
        offer(path_of(0, 0, -100, 0, 1000, 100));         // rising onto the bound
        offer(path_of(0, 0, -100, 0, 1002, 100));         // rising past the bound
        offer(path_of(0, 300, 10, 100, 300, 10));         // parallel
        offer(path_of(-500, 300, 0, 500, 300, 0));        // collinear overlap
        offer(path_of(0, 300, 0, 0, 300, 0));             // zero length
        offer(path_of(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        offer(path_of(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX));
        offer(path_of(C_MIN, 200, C_MIN, C_MAX, 200, C_MAX));

        // Random phases, one wall setting each; no idling in the last one
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            wall_now = make_wall(PHASE_WALLS[ph]);
            write_wall(wall_now);
            if (ph == N_PHASES - 1) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
                rx_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
            end
            repeat (PHASE_ITEMS) offer(make_random(wall_now));
        end

        // Drain, then allow the pipeline depth for any stray flag
        settle();
        repeat (NSTAGE + 8) @(posedge i_clk);
        if (board.n_bad == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/wsct_pkg.sv
rtl/wsct_pipe_ctl.sv
rtl/wall_segment_crossing_test.sv
rtl/wsct_checker.sv
sim/crossing_check_pkg.sv
sim/tb_top.sv
